// ----- rtl/core/stream_byte_mutator_xoshiro_macros.svh -----
// Assertion macros shared by the mutator RTL.
`ifndef STREAM_BYTE_MUTATOR_XOSHIRO_MACROS_SVH
`define STREAM_BYTE_MUTATOR_XOSHIRO_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBMX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBMX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sbmx_pkg.sv -----
`timescale 1ns / 1ps

package sbmx_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP  = 2'd3;

  // Field and state widths.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned REG_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 8;

  // Generator shift and rotate amounts.
  localparam int unsigned ROT_OUT = 23;
  localparam int unsigned SHL_MIX = 17;
  localparam int unsigned ROT_MIX = 45;

  // Register reset values.
  localparam logic [REG_W-1:0] SEED_RST  = 32'd1;
  localparam logic [REG_W-1:0] NUMER_RST = 32'd1;
  localparam logic [REG_W-1:0] DENOM_RST = 32'd1000;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Status of the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Rotate a 64-bit word left by a constant amount.
  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                               input int unsigned amt);
    rotl64 = (v << amt) | (v >> (WORD_W - amt));
  endfunction

endpackage

// ----- rtl/core/sbmx_moddiv.sv -----
`timescale 1ns / 1ps

`include "stream_byte_mutator_xoshiro_macros.svh"

// Restoring divider that keeps only the remainder of a 64-bit dividend by a
// 32-bit divisor, one dividend bit per cycle.
module sbmx_moddiv
  import sbmx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [REG_W-1:0]  divisor,
  output div_status_t       status,
  output logic [REG_W-1:0]  remainder
);

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] quo;
  logic [REG_W-1:0]  den;
  logic [REG_W-1:0]  rem;
  logic [REG_W:0]    trial;
  logic [REG_W+1:0]  diff;

  // Shift the next dividend bit in and try the subtraction.
  always_comb begin
    trial = {rem, quo[WORD_W-1]};
    diff  = {1'b0, trial} - {2'b00, den};
  end

  // Control: busy until every dividend bit has been taken in, then done pulses.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == {CNT_W{1'b1}}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: keep the difference when it does not go negative.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[WORD_W-2:0], 1'b0};
      if (!diff[REG_W+1]) begin
        rem <= diff[REG_W-1:0];
      end else begin
        rem <= trial[REG_W-1:0];
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign remainder   = rem;

  `SBMX_ASSERT_NEXT(a_start_busy, clk, rst, start, busy, "divider did not start")
  `SBMX_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "divider done while busy")
  `SBMX_ASSERT_NOW(a_rem_range, clk, rst, done, rem < den, "remainder not reduced")

endmodule

// ----- rtl/core/stream_byte_mutator_xoshiro.sv -----
`timescale 1ns / 1ps

// Stream byte mutator with a xoshiro256++ generator.
// Input bytes arrive on the s_axis channel and leave, one result per byte,
// on the m_axis channel; m_axis_tuser is high when the byte was replaced.
// The cfg port writes seed (0), numerator (1), denominator (2) and sync skip
// (3); a seed write reloads the generator words. Write only while idle.
// A passed sync byte goes from idle straight to the emit state, which sets
// m_axis_tvalid once the output register is free. A drawn byte forms the
// random word in the mix state, goes through the bit-serial remainder unit
// in the divide state, where the remainder is taken, and reaches the output
// register from the emit state; with a zero denominator the remainder unit
// is skipped. The input accepts the next byte in the cycle after the current
// one has moved into the output stage, so a result may wait in the output
// register while the next byte is processed. Reset loads seed 1, numerator 1,
// denominator 1000, sync skip on, generator words (1, 0, 0, 1) and packet
// position zero. When the receiver stalls, the finished result holds in the
// output register and the next finished result waits in the sequencer until
// the output register is free.
module stream_byte_mutator_xoshiro
  import sbmx_pkg::*;
#(
  parameter int PACKET_LEN = 188
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [BYTE_W-1:0]    s_axis_tdata,   // byte_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [BYTE_W-1:0]    m_axis_tdata,   // byte_out
  output logic                 m_axis_tuser,   // was_changed
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam logic [POS_W:0] PKT_LEN_C = (POS_W + 1)'(PACKET_LEN);

  state_t            state;
  state_t            state_next;
  logic [REG_W-1:0]  chance_numerator;
  logic [REG_W-1:0]  chance_denominator;
  logic              skip_sync;
  logic [WORD_W-1:0] gen_word [4];
  logic [POS_W-1:0]  packet_pos;
  logic [POS_W:0]    pos_inc;
  logic [WORD_W-1:0] sum_reg;
  logic [WORD_W-1:0] rnd_word;
  logic [BYTE_W-1:0] rnd_byte;
  logic [BYTE_W-1:0] res_byte;
  logic              res_changed;
  logic              in_fire;
  logic              at_sync;
  logic              out_free;
  logic              out_load;
  logic              div_start;
  div_status_t       div_st;
  logic [REG_W-1:0]  div_rem;
  logic [WORD_W-1:0] mix_shift;
  logic [WORD_W-1:0] mix2;
  logic [WORD_W-1:0] mix3;
  logic [WORD_W-1:0] mix1;
  logic [WORD_W-1:0] mix0;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign at_sync  = skip_sync && (packet_pos == '0);
  assign pos_inc  = {1'b0, packet_pos} + 1'b1;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Output word and generator advance, both from the current words.
  always_comb begin
    rnd_word  = rotl64(sum_reg, ROT_OUT) + gen_word[0];
    mix_shift = gen_word[1] << SHL_MIX;
    mix2      = gen_word[2] ^ gen_word[0];
    mix3      = gen_word[3] ^ gen_word[1];
    mix1      = gen_word[1] ^ mix2;
    mix0      = gen_word[0] ^ mix3;
  end

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = at_sync ? ST_EMIT : ST_MIX;
        end
      end
      ST_MIX: begin
        if (chance_denominator != '0) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers, generator words and packet position.
  always_ff @(posedge clk) begin
    if (rst) begin
      chance_numerator   <= NUMER_RST;
      chance_denominator <= DENOM_RST;
      skip_sync          <= 1'b1;
      gen_word[0]        <= {{(WORD_W-REG_W){1'b0}}, SEED_RST};
      gen_word[1]        <= '0;
      gen_word[2]        <= '0;
      gen_word[3]        <= {{(WORD_W-1){1'b0}}, 1'b1};
      packet_pos         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEED: begin
            gen_word[0] <= {{(WORD_W-REG_W){1'b0}}, cfg_data};
            gen_word[1] <= '0;
            gen_word[2] <= '0;
            gen_word[3] <= {{(WORD_W-1){1'b0}}, 1'b1};
          end
          CFG_NUMER: chance_numerator   <= cfg_data;
          CFG_DENOM: chance_denominator <= cfg_data;
          CFG_SKIP:  skip_sync          <= cfg_data[0];
          default: begin
          end
        endcase
      end else if (state == ST_MIX) begin
        gen_word[0] <= mix0;
        gen_word[1] <= mix1;
        gen_word[2] <= mix2 ^ mix_shift;
        gen_word[3] <= rotl64(mix3, ROT_MIX);
      end
      if (in_fire && skip_sync) begin
        packet_pos <= (pos_inc >= PKT_LEN_C) ? '0 : pos_inc[POS_W-1:0];
      end
    end
  end

  // Working registers for the byte in flight.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sum_reg     <= gen_word[0] + gen_word[3];
      res_byte    <= s_axis_tdata;
      res_changed <= 1'b0;
    end
    if (state == ST_MIX) begin
      rnd_byte <= rnd_word[BYTE_W-1:0];
    end
    if (state == ST_DIV && div_st.done && div_rem < chance_numerator) begin
      res_byte    <= rnd_byte;
      res_changed <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res_byte;
      m_axis_tuser <= res_changed;
    end
  end

  // Remainder of the drawn word by the denominator.
  sbmx_moddiv u_moddiv (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rnd_word),
    .divisor   (chance_denominator),
    .status    (div_st),
    .remainder (div_rem)
  );

  `SBMX_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_fire, state != ST_IDLE,
    "sequencer stayed idle after an accepted byte")
  `SBMX_ASSERT_NOW(a_pos_range, clk, rst, 1'b1, {1'b0, packet_pos} < PKT_LEN_C,
    "packet position out of range")
  `SBMX_ASSERT_NOW(a_done_in_div, clk, rst, div_st.done, state == ST_DIV,
    "remainder finished outside the divide state")
  `SBMX_ASSERT_NOW(a_load_free, clk, rst, out_load, out_free,
    "output register loaded while occupied")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sbmx_pkg::*;

  localparam int FRAME_BYTES = 188;
  localparam int HOLD_CYCLES = 1500;
  localparam int STALL_LIMIT = 10000;
  localparam int END_CYCLES  = 100;

  // One output transaction: the byte and its replaced flag.
  typedef struct packed {
    logic [BYTE_W-1:0] out_value;
    logic              replaced;
  } mut_result_t;

  // One row of the directed plan: a register write or a byte, with an
  // optional expected result typed in by hand.
  typedef struct packed {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [REG_W-1:0]     wdata;
    logic [BYTE_W-1:0]    din;
    bit                   known;
    logic [BYTE_W-1:0]    want_value;
    bit                   want_replaced;
  } step_row_t;

  localparam int PLAN_LEN = 29;
  localparam step_row_t PLAN [PLAN_LEN] = '{
    // Sync byte right after reset passes untouched.
    '{1'b0, CFG_SEED,  32'd0,        8'h00, 1'b1, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'hFF, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'hA5, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'h01, 1'b0, 8'h00, 1'b0},
    // Zero denominator never mutates.
    '{1'b1, CFG_DENOM, 32'd0,        8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'h5A, 1'b1, 8'h5A, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'hFF, 1'b1, 8'hFF, 1'b0},
    // Denominator one with the largest numerator mutates every drawn byte.
    '{1'b1, CFG_NUMER, 32'hFFFFFFFF, 8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b1, CFG_DENOM, 32'd1,        8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'hFF, 1'b0, 8'h00, 1'b0},
    // Sync skipping off: the packet position holds.
    '{1'b1, CFG_SKIP,  32'd0,        8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'h80, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'h7F, 1'b0, 8'h00, 1'b0},
    '{1'b1, CFG_SEED,  32'hFFFFFFFF, 8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'h55, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'hAA, 1'b0, 8'h00, 1'b0},
    // Zero numerator never mutates.
    '{1'b1, CFG_NUMER, 32'd0,        8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'h3C, 1'b1, 8'h3C, 1'b0},
    '{1'b1, CFG_SEED,  32'd0,        8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b1, CFG_SKIP,  32'd1,        8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'hC3, 1'b0, 8'h00, 1'b0},
    '{1'b1, CFG_DENOM, 32'hFFFFFFFF, 8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b1, CFG_NUMER, 32'h80000000, 8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'h12, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_SEED,  32'd0,        8'hED, 1'b0, 8'h00, 1'b0},
    // Back to the reset settings.
    '{1'b1, CFG_SEED,  SEED_RST,     8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b1, CFG_NUMER, NUMER_RST,    8'h00, 1'b0, 8'h00, 1'b0},
    '{1'b1, CFG_DENOM, DENOM_RST,    8'h00, 1'b0, 8'h00, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [BYTE_W-1:0]    s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  // Predictor copy of the registers and the generator state.
  logic [REG_W-1:0]  seed_r  = SEED_RST;
  logic [REG_W-1:0]  numer_r = NUMER_RST;
  logic [REG_W-1:0]  denom_r = DENOM_RST;
  logic              skip_r  = 1'b1;
  logic [WORD_W-1:0] gen [4] = '{64'd1, 64'd0, 64'd0, 64'd1};
  logic [POS_W-1:0]  frame_pos = '0;

  mut_result_t pending_results [$];
  mut_result_t head_result;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  stream_byte_mutator_xoshiro #(
    .PACKET_LEN(FRAME_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // byte_in
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // byte_out
    .m_axis_tuser (m_axis_tuser),   // was_changed
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] spin_left(input logic [WORD_W-1:0] v,
                                                  input int unsigned amt);
    return (v << amt) | (v >> (WORD_W - amt));
  endfunction

  // Draw one value and step the generator words.
  function automatic logic [WORD_W-1:0] advance_generator();
    logic [WORD_W-1:0] drawn;
    logic [WORD_W-1:0] carry;
    drawn  = spin_left(gen[0] + gen[3], ROT_OUT) + gen[0];
    carry  = gen[1] << SHL_MIX;
    gen[2] = gen[2] ^ gen[0];
    gen[3] = gen[3] ^ gen[1];
    gen[1] = gen[1] ^ gen[2];
    gen[0] = gen[0] ^ gen[3];
    gen[2] = gen[2] ^ carry;
    gen[3] = spin_left(gen[3], ROT_MIX);
    return drawn;
  endfunction

  // Expected output for one accepted byte; updates position and generator.
  function automatic mut_result_t predict_mutation(input logic [BYTE_W-1:0] din);
    mut_result_t       res;
    logic              at_sync;
    logic [WORD_W-1:0] drawn;
    res.out_value = din;
    res.replaced  = 1'b0;
    if (skip_r) begin
      at_sync   = (frame_pos == '0);
      frame_pos = (frame_pos + 1 >= FRAME_BYTES) ? '0 : frame_pos + 1'b1;
      if (at_sync) return res;
    end
    drawn = advance_generator();
    if (denom_r != '0 && (drawn % {32'd0, denom_r}) < {32'd0, numer_r}) begin
      res.out_value = drawn[BYTE_W-1:0];
      res.replaced  = 1'b1;
    end
    return res;
  endfunction

  // Offer one byte until accepted, then queue its expected result.
  task automatic offer_byte(input logic [BYTE_W-1:0] din, input bit known,
                            input mut_result_t typed);
    mut_result_t guess;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    guess = predict_mutation(din);
    pending_results.push_back(known ? typed : guess);
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write; the predictor follows the same register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] wdata);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SEED: begin
        seed_r = wdata;
        gen    = '{{32'd0, wdata}, 64'd0, 64'd0, 64'd1};
      end
      CFG_NUMER: numer_r = wdata;
      CFG_DENOM: denom_r = wdata;
      CFG_SKIP:  skip_r  = wdata[0];
      default: ;
    endcase
  endtask

  // One random phase: new settings, an idling mix, then random bytes.
  task automatic run_phase(input logic [REG_W-1:0] seed, input logic [REG_W-1:0] numer,
                           input logic [REG_W-1:0] denom, input logic skip,
                           input int send_pct, input int stall_pct, input int count,
                           input bit hold, input bit pause);
    mut_result_t blank;
    blank = '0;
    settle_results();
    write_reg(CFG_SEED, seed);
    write_reg(CFG_NUMER, numer);
    write_reg(CFG_DENOM, denom);
    write_reg(CFG_SKIP, {31'd0, skip});
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_req++;
    for (int i = 0; i < count; i++) begin
      if (pause && i == count / 2) settle_results();
      offer_byte(8'($urandom_range(255)), 1'b0, blank);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each output transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: byte_out %02h was_changed %0b",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (m_axis_tdata !== head_result.out_value) begin
          $error("byte_out: expected %02h, actual %02h", head_result.out_value, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== head_result.replaced) begin
          $error("was_changed: expected %0b, actual %0b", head_result.replaced, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mut_result_t typed;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan.
    foreach (PLAN[k]) begin
      if (PLAN[k].is_write) begin
        settle_results();
        write_reg(PLAN[k].idx, PLAN[k].wdata);
      end else begin
        typed.out_value = PLAN[k].want_value;
        typed.replaced  = PLAN[k].want_replaced;
        offer_byte(PLAN[k].din, PLAN[k].known, typed);
      end
    end

    // Random phases over several settings and idling mixes.
    run_phase(SEED_RST, NUMER_RST, DENOM_RST, 1'b1, 0, 0, 160, 1'b0, 1'b0);
    run_phase($urandom, 32'd1, 32'd2, 1'b1, 67, 0, 160, 1'b0, 1'b0);
    run_phase($urandom, $urandom, $urandom, 1'b0, 0, 67, 160, 1'b1, 1'b0);
    run_phase($urandom, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 22, 22, 160, 1'b0, 1'b0);
    run_phase($urandom, $urandom, 32'd0, 1'($urandom_range(1)), 0, 0, 160, 1'b0, 1'b0);
    run_phase(32'd0, 32'd1, 32'd1, 1'b1, 67, 0, 160, 1'b0, 1'b1);
    run_phase($urandom, $urandom_range(16), $urandom_range(16, 1), 1'b1, 0, 67, 160,
              1'b0, 1'b0);
    run_phase($urandom, $urandom, $urandom, 1'($urandom_range(1)), 22, 22, 160, 1'b0, 1'b0);

    settle_results();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
